[hdl/etf_pkg.sv]
// shared types and constants of the envelope template fit block
`default_nettype none
package etf_pkg;

  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned SCALE_W     = 32;
  localparam int unsigned SUM_W       = 36;
  localparam int unsigned SQ_W        = 60;
  localparam int unsigned Q_W         = 16;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned SRCH_STEPS  = 16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FEW       = 3'd1,
    ST_ZERO_VAR  = 3'd2,
    ST_ZERO_PEAK = 3'd3,
    ST_OVERFLOW  = 3'd4
  } fit_status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR_RES,
    OP_MUL,
    OP_SEARCH,
    OP_WRITE
  } cmd_op_e;

  // operand pairs of the serial multiplier
  typedef enum logic [3:0] {
    MS_NSXX,
    MS_SXSX,
    MS_NSYY,
    MS_SYSY,
    MS_NSXY,
    MS_SXSY,
    MS_VAVB,
    MS_CVCV,
    MS_SS,
    MS_POPP,
    MS_CA
  } mul_sel_e;

  // quotient searches
  typedef enum logic [1:0] {
    SS_CORR,
    SS_AMP,
    SS_FIT
  } srch_sel_e;

  typedef struct packed {
    logic        accept;
    cmd_op_e     op;
    mul_sel_e    mul_sel;
    srch_sel_e   srch_sel;
    fit_status_e status;
  } etf_cmd_t;

  typedef struct packed {
    logic ovf;
    logic few;
    logic zero_peak;
    logic pos_a;
    logic pos_b;
    logic pos_c;
    logic mul_done;
    logic srch_done;
  } etf_stat_t;

endpackage
`default_nettype wire

[hdl/etf_if.sv]
// request channels of the envelope template fit block
`default_nettype none
interface etf_in_if;
  import etf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] obs_sample;
  logic [SAMPLE_W-1:0] template_sample;
  logic                last_sample;
  modport source (output valid, obs_sample, template_sample, last_sample, input ready);
  modport sink (input valid, obs_sample, template_sample, last_sample, output ready);
endinterface

interface etf_out_if;
  import etf_pkg::*;
  logic                valid;
  logic                ready;
  logic [Q_W-1:0]      fit_value;
  logic [Q_W-1:0]      correlation_value;
  logic [Q_W-1:0]      amplitude_fit;
  logic [SAMPLE_W-1:0] peak_observed;
  logic [SAMPLE_W-1:0] peak_predicted;
  logic [LEN_W-1:0]    window_length;
  logic [STAT_W-1:0]   fit_status;
  modport source (output valid, fit_value, correlation_value, amplitude_fit, peak_observed,
                  peak_predicted, window_length, fit_status, input ready);
  modport sink (input valid, fit_value, correlation_value, amplitude_fit, peak_observed,
                peak_predicted, window_length, fit_status, output ready);
endinterface

interface etf_cfg_if;
  import etf_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] template_scale;
  modport source (output valid, template_scale, input ready);
  modport sink (input valid, template_scale, output ready);
endinterface
`default_nettype wire

[hdl/etf_datapath.sv]
// accumulators, serial multiplier, quotient search and result register
`default_nettype none
module etf_datapath #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire etf_pkg::etf_cmd_t                 cmd_i,
  output etf_pkg::etf_stat_t                     stat_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [etf_pkg::SCALE_W-1:0]       cfg_scale_i,
  input  wire logic [etf_pkg::SAMPLE_W-1:0]      obs_sample_i,
  input  wire logic [etf_pkg::SAMPLE_W-1:0]      template_sample_i,
  output logic [etf_pkg::Q_W-1:0]                fit_value_o,
  output logic [etf_pkg::Q_W-1:0]                correlation_value_o,
  output logic [etf_pkg::Q_W-1:0]                amplitude_fit_o,
  output logic [etf_pkg::SAMPLE_W-1:0]           peak_observed_o,
  output logic [etf_pkg::SAMPLE_W-1:0]           peak_predicted_o,
  output logic [etf_pkg::LEN_W-1:0]              window_length_o,
  output logic [etf_pkg::STAT_W-1:0]             fit_status_o
);
  import etf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned VAR_W = (CNT_W + SQ_W > 2 * SUM_W) ? CNT_W + SQ_W : 2 * SUM_W;
  localparam int unsigned PW    = 2 * VAR_W;
  localparam int unsigned SW    = PW + 32;
  localparam logic [SAMPLE_W-1:0] SMAX =
    SAMPLE_W'((25'(1) << SAMPLE_BITS) - 25'(1));
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  logic [SCALE_W-1:0]  scale_q;
  logic [SAMPLE_W-1:0] x1_q, y1_q;
  logic                s1_vld_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SAMPLE_W-1:0] po_q, pp_q;
  logic [SUM_W-1:0]    sx_q, sy_q;
  logic [SQ_W-1:0]     sxx_q, syy_q, sxy_q;
  logic                ovf_q;

  // input scaling
  logic [SAMPLE_W-1:0]     x_in, t_in, y_in;
  logic [55:0]             scl_prod;
  logic [56:0]             scl_rnd;
  logic [32:0]             y_full;
  always_comb begin
    x_in     = obs_sample_i & SMAX;
    t_in     = template_sample_i & SMAX;
    scl_prod = 56'(t_in) * 56'(scale_q);
    scl_rnd  = 57'(scl_prod) + 57'(1 << 23);
    y_full   = scl_rnd[56:24];
    y_in     = (y_full > 33'(SMAX)) ? SMAX : y_full[SAMPLE_W-1:0];
  end

  // products and saturating sums of the second stage
  logic [47:0]     xx, yy, xy;
  logic [SUM_W:0]  sx_sum, sy_sum;
  logic [SQ_W:0]   sxx_sum, syy_sum, sxy_sum;
  always_comb begin
    xx      = 48'(x1_q) * 48'(x1_q);
    yy      = 48'(y1_q) * 48'(y1_q);
    xy      = 48'(x1_q) * 48'(y1_q);
    sx_sum  = {1'b0, sx_q} + (SUM_W+1)'(x1_q);
    sy_sum  = {1'b0, sy_q} + (SUM_W+1)'(y1_q);
    sxx_sum = {1'b0, sxx_q} + (SQ_W+1)'(xx);
    syy_sum = {1'b0, syy_q} + (SQ_W+1)'(yy);
    sxy_sum = {1'b0, sxy_q} + (SQ_W+1)'(xy);
  end

  // configuration, first stage and window accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RESET;
      s1_vld_q <= 1'b0;
      cnt_q    <= '0;
      po_q     <= '0;
      pp_q     <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      sxx_q    <= '0;
      syy_q    <= '0;
      sxy_q    <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_scale_i;
      end
      s1_vld_q <= cmd_i.accept;
      if (cmd_i.op == OP_WRITE) begin
        cnt_q <= '0;
        po_q  <= '0;
        pp_q  <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
        ovf_q <= 1'b0;
      end else if (s1_vld_q) begin
        if (cnt_q >= CNT_MAX) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (x1_q > po_q) po_q <= x1_q;
          if (y1_q > pp_q) pp_q <= y1_q;
          sx_q  <= sx_sum[SUM_W]  ? '1 : sx_sum[SUM_W-1:0];
          sy_q  <= sy_sum[SUM_W]  ? '1 : sy_sum[SUM_W-1:0];
          sxx_q <= sxx_sum[SQ_W]  ? '1 : sxx_sum[SQ_W-1:0];
          syy_q <= syy_sum[SQ_W]  ? '1 : syy_sum[SQ_W-1:0];
          sxy_q <= sxy_sum[SQ_W]  ? '1 : sxy_sum[SQ_W-1:0];
          if (sx_sum[SUM_W] || sy_sum[SUM_W] || sxx_sum[SQ_W] || syy_sum[SQ_W] ||
              sxy_sum[SQ_W]) begin
            ovf_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x1_q <= x_in;
      y1_q <= y_in;
    end
  end

  // serial shift-add multiplier
  logic [PW-1:0]    ma_q, macc_q, op_a;
  logic [VAR_W-1:0] mb_q, op_b;
  logic             mbusy_q, mul_done;
  mul_sel_e         msel_q;
  logic [VAR_W-1:0] t_q, va_q, vb_q, cv_q;
  logic             pa_q, pb_q, pc_q;
  logic [PW-1:0]    lhs_q;
  logic [SW-1:0]    rhs_q;
  logic [Q_W-1:0]   corr_q, amp_q, fit_q;
  logic [SAMPLE_W:0] peak_sum;

  assign peak_sum = (SAMPLE_W+1)'(po_q) + (SAMPLE_W+1)'(pp_q);
  assign mul_done = mbusy_q && (mb_q == '0);

  // operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      MS_NSXX: begin op_a = PW'(sxx_q);   op_b = VAR_W'(cnt_q); end
      MS_SXSX: begin op_a = PW'(sx_q);    op_b = VAR_W'(sx_q);  end
      MS_NSYY: begin op_a = PW'(syy_q);   op_b = VAR_W'(cnt_q); end
      MS_SYSY: begin op_a = PW'(sy_q);    op_b = VAR_W'(sy_q);  end
      MS_NSXY: begin op_a = PW'(sxy_q);   op_b = VAR_W'(cnt_q); end
      MS_SXSY: begin op_a = PW'(sx_q);    op_b = VAR_W'(sy_q);  end
      MS_VAVB: begin op_a = PW'(va_q);    op_b = vb_q;          end
      MS_CVCV: begin op_a = PW'(cv_q);    op_b = cv_q;          end
      MS_SS:   begin op_a = PW'(peak_sum); op_b = VAR_W'(peak_sum); end
      MS_POPP: begin op_a = PW'(po_q);    op_b = VAR_W'(pp_q);  end
      MS_CA:   begin op_a = PW'(corr_q);  op_b = VAR_W'(amp_q); end
      default: begin op_a = '0;           op_b = '0;            end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
    end else if (cmd_i.op == OP_MUL) begin
      mbusy_q <= 1'b1;
    end else if (mul_done) begin
      mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MUL) begin
      ma_q   <= op_a;
      mb_q   <= op_b;
      macc_q <= '0;
      msel_q <= cmd_i.mul_sel;
    end else if (mbusy_q && !mul_done) begin
      if (mb_q[0]) macc_q <= macc_q + ma_q;
      ma_q <= ma_q << 1;
      mb_q <= mb_q >> 1;
    end
  end

  // product destinations: spreads and search operands
  logic           spread_pos;
  logic [PW-1:0]  spread_val;
  always_comb begin
    spread_pos = PW'(t_q) > macc_q;
    spread_val = PW'(t_q) - macc_q;
  end

  always_ff @(posedge clk_i) begin
    if (mul_done) begin
      case (msel_q)
        MS_NSXX, MS_NSYY, MS_NSXY: t_q <= macc_q[VAR_W-1:0];
        MS_SXSX: begin
          pa_q <= spread_pos;
          va_q <= spread_pos ? spread_val[VAR_W-1:0] : '0;
        end
        MS_SYSY: begin
          pb_q <= spread_pos;
          vb_q <= spread_pos ? spread_val[VAR_W-1:0] : '0;
        end
        MS_SXSY: begin
          pc_q <= spread_pos;
          cv_q <= spread_pos ? spread_val[VAR_W-1:0] : '0;
        end
        MS_VAVB: lhs_q <= macc_q;
        MS_CVCV: rhs_q <= SW'(macc_q) << 30;
        MS_SS:   lhs_q <= macc_q;
        MS_POPP: rhs_q <= SW'(macc_q) << 17;
        MS_CA: begin
          rhs_q <= SW'(macc_q);
          lhs_q <= PW'(1);
        end
        default: ;
      endcase
    end
  end

  // restoring quotient search, one result bit per cycle
  logic [SW-1:0]  sp_q, sqp_q, sq2_q, sr_q, trial;
  logic [Q_W-1:0] sq_q;
  logic [4:0]     scnt_q;
  logic           sbusy_q, srch_done, s_square, t_fits;
  srch_sel_e      ssel_q;

  assign srch_done = sbusy_q && (scnt_q == '0);
  assign s_square  = (ssel_q != SS_AMP);
  assign trial     = sq2_q + sqp_q + sp_q;
  assign t_fits    = trial <= sr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
    end else if (cmd_i.op == OP_SEARCH) begin
      sbusy_q <= 1'b1;
    end else if (srch_done) begin
      sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SEARCH) begin
      ssel_q <= cmd_i.srch_sel;
      sp_q   <= (cmd_i.srch_sel != SS_AMP) ? (SW'(lhs_q) << 30) : (SW'(lhs_q) << 15);
      sqp_q  <= '0;
      sq2_q  <= '0;
      sr_q   <= rhs_q;
      sq_q   <= '0;
      scnt_q <= 5'(SRCH_STEPS);
    end else if (sbusy_q && !srch_done) begin
      if (t_fits) begin
        sq2_q <= trial;
        sq_q[4'(scnt_q - 5'd1)] <= 1'b1;
      end
      sqp_q  <= (sqp_q >> 1) + ((t_fits && s_square) ? sp_q : '0);
      sp_q   <= s_square ? (sp_q >> 2) : (sp_q >> 1);
      scnt_q <= scnt_q - 5'd1;
    end
  end

  // fit terms
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLEAR_RES) begin
      corr_q <= '0;
      amp_q  <= '0;
      fit_q  <= '0;
    end else if (srch_done) begin
      case (ssel_q)
        SS_CORR: corr_q <= sq_q;
        SS_AMP:  amp_q  <= sq_q;
        SS_FIT:  fit_q  <= sq_q;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) begin
      fit_status_o        <= cmd_i.status;
      fit_value_o         <= (cmd_i.status == ST_OK) ? fit_q  : '0;
      correlation_value_o <= (cmd_i.status == ST_OK) ? corr_q : '0;
      amplitude_fit_o     <= (cmd_i.status == ST_OK) ? amp_q  : '0;
      peak_observed_o     <= po_q;
      peak_predicted_o    <= pp_q;
      window_length_o     <= LEN_W'(cnt_q);
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.ovf       = ovf_q;
    stat_o.few       = cnt_q < CNT_W'(2);
    stat_o.zero_peak = (po_q == '0) || (pp_q == '0);
    stat_o.pos_a     = pa_q;
    stat_o.pos_b     = pb_q;
    stat_o.pos_c     = pc_q;
    stat_o.mul_done  = mul_done;
    stat_o.srch_done = srch_done;
  end

endmodule
`default_nettype wire

[hdl/etf_ctrl.sv]
// controller sequencing accumulation, finishing steps and result hand-off
`default_nettype none
module etf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire etf_pkg::etf_stat_t stat_i,
  output etf_pkg::etf_cmd_t       cmd_o
);
  import etf_pkg::*;

  typedef enum logic [2:0] {
    S_ACC,
    S_DRAIN,
    S_CHK,
    S_ISSUE,
    S_WAIT,
    S_NEXT,
    S_WRITE
  } state_e;

  localparam logic [3:0] STEP_LAST_SPREAD = 4'd5;
  localparam logic [3:0] STEP_VAVB        = 4'd6;
  localparam logic [3:0] STEP_SS          = 4'd9;
  localparam logic [3:0] STEP_FIT         = 4'd13;

  state_e      state_q;
  logic [3:0]  step_q;
  fit_status_e stat_q;
  logic        out_valid_q;
  logic        in_fire, out_free;

  // finishing program
  logic      step_search;
  mul_sel_e  step_mul;
  srch_sel_e step_srch;
  always_comb begin
    step_search = 1'b0;
    step_mul    = MS_NSXX;
    step_srch   = SS_CORR;
    case (step_q)
      4'd0:  step_mul = MS_NSXX;
      4'd1:  step_mul = MS_SXSX;
      4'd2:  step_mul = MS_NSYY;
      4'd3:  step_mul = MS_SYSY;
      4'd4:  step_mul = MS_NSXY;
      4'd5:  step_mul = MS_SXSY;
      4'd6:  step_mul = MS_VAVB;
      4'd7:  step_mul = MS_CVCV;
      4'd8:  begin step_search = 1'b1; step_srch = SS_CORR; end
      4'd9:  step_mul = MS_SS;
      4'd10: step_mul = MS_POPP;
      4'd11: begin step_search = 1'b1; step_srch = SS_AMP; end
      4'd12: step_mul = MS_CA;
      4'd13: begin step_search = 1'b1; step_srch = SS_FIT; end
      default: step_mul = MS_NSXX;
    endcase
  end

  assign in_ready_o  = (state_q == S_ACC);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // commands to the datapath
  always_comb begin
    cmd_o.accept   = in_fire;
    cmd_o.op       = OP_NONE;
    cmd_o.mul_sel  = step_mul;
    cmd_o.srch_sel = step_srch;
    cmd_o.status   = stat_q;
    case (state_q)
      S_CHK:   if (!stat_i.ovf && !stat_i.few && !stat_i.zero_peak) cmd_o.op = OP_CLEAR_RES;
      S_ISSUE: cmd_o.op = step_search ? OP_SEARCH : OP_MUL;
      S_WRITE: if (out_free) cmd_o.op = OP_WRITE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      step_q      <= '0;
      stat_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_WRITE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_ACC: begin
          if (in_fire && in_last_i) state_q <= S_DRAIN;
        end
        S_DRAIN: state_q <= S_CHK;
        S_CHK: begin
          if (stat_i.ovf) begin
            stat_q  <= ST_OVERFLOW;
            state_q <= S_WRITE;
          end else if (stat_i.few) begin
            stat_q  <= ST_FEW;
            state_q <= S_WRITE;
          end else if (stat_i.zero_peak) begin
            stat_q  <= ST_ZERO_PEAK;
            state_q <= S_WRITE;
          end else begin
            step_q  <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (stat_i.mul_done || stat_i.srch_done) state_q <= S_NEXT;
        end
        S_NEXT: begin
          if (step_q == STEP_LAST_SPREAD) begin
            if (!stat_i.pos_a || !stat_i.pos_b) begin
              stat_q  <= ST_ZERO_VAR;
              state_q <= S_WRITE;
            end else begin
              step_q  <= stat_i.pos_c ? STEP_VAVB : STEP_SS;
              state_q <= S_ISSUE;
            end
          end else if (step_q == STEP_FIT) begin
            stat_q  <= ST_OK;
            state_q <= S_WRITE;
          end else begin
            step_q  <= step_q + 4'd1;
            state_q <= S_ISSUE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            state_q <= S_ACC;
          end
        end
        default: state_q <= S_ACC;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/envelope_template_fit_top.sv]
// top level of the envelope template fit block
// sample pairs are taken one per cycle while a window accumulates; input stalls after the last pair
// in the worst case a result takes 11 serial multiplies, each shifting through its second operand
// (13 to 73 bits wide) until that operand is zero, and 3 quotient searches after the last pair;
// windows with overflow, few pairs or a zero peak skip both; next window once result is held
// reset is asynchronous, active low; it clears the window and sets template_scale to 1.0
`default_nettype none
module envelope_template_fit_top #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  etf_in_if.sink     in_ch,
  etf_out_if.source  out_ch,
  etf_cfg_if.sink    cfg_ch
);
  import etf_pkg::*;

  etf_cmd_t  cmd;
  etf_stat_t stat;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  etf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_last_i   (in_ch.last_sample),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  etf_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_ch.valid),
    .cfg_scale_i         (cfg_ch.template_scale),
    .obs_sample_i        (in_ch.obs_sample),
    .template_sample_i   (in_ch.template_sample),
    .fit_value_o         (out_ch.fit_value),
    .correlation_value_o (out_ch.correlation_value),
    .amplitude_fit_o     (out_ch.amplitude_fit),
    .peak_observed_o     (out_ch.peak_observed),
    .peak_predicted_o    (out_ch.peak_predicted),
    .window_length_o     (out_ch.window_length),
    .fit_status_o        (out_ch.fit_status)
  );

endmodule
`default_nettype wire

[bench/etf_fit_checker.sv]
// checker of the envelope template fit block: predicts each window result and compares it
`default_nettype none
module etf_fit_checker
  import etf_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  etf_in_if           in_ch,
  etf_out_if          out_ch,
  etf_cfg_if          cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned WINDOW_MAX = 4096;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;
  localparam logic [SUM_W-1:0] SUM_TOP = '1;
  localparam logic [SQ_W-1:0] SQ_TOP = '1;

  typedef logic [255:0] wide_t;

  typedef struct packed {
    logic [Q_W-1:0]      fit_value;
    logic [Q_W-1:0]      correlation_value;
    logic [Q_W-1:0]      amplitude_fit;
    logic [SAMPLE_W-1:0] peak_observed;
    logic [SAMPLE_W-1:0] peak_predicted;
    logic [LEN_W-1:0]    window_length;
    fit_status_e         fit_status;
  } fit_result_t;

  // window accumulators of the predictor
  logic [SCALE_W-1:0]  gain;
  int unsigned         pairs;
  logic [SAMPLE_W-1:0] obs_peak, tpl_peak;
  logic [SUM_W-1:0]    obs_sum, tpl_sum;
  logic [SQ_W-1:0]     obs_sq, tpl_sq, cross_sq;
  logic                window_ovf;

  fit_result_t expected_results[$];
  int unsigned fails;

  // n*s2 - a*b, floored at zero
  function automatic wide_t spread(input wide_t n, input wide_t s2, input wide_t a,
                                   input wide_t b, output bit positive);
    wide_t p, q;
    p = n * s2;
    q = a * b;
    positive = p > q;
    return positive ? p - q : '0;
  endfunction

  // largest q in 0..32768 with f(q)*lhs <= rhs, f(q) = q or q*q
  function automatic int unsigned quotient_search(input wide_t lhs, input wide_t rhs,
                                                  input bit squared);
    int unsigned lo, hi, mid;
    wide_t f;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      f = squared ? wide_t'(mid) * wide_t'(mid) : wide_t'(mid);
      if (f * lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic int unsigned int_sqrt(input longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return int'(lo);
  endfunction

  function automatic fit_result_t window_result();
    fit_result_t r;
    bit pa, pb, pc;
    wide_t va, vb, cv;
    int unsigned corr, amp;
    longint unsigned s;
    corr = 0;
    amp = 0;
    r = '0;
    r.fit_status = ST_OK;
    if (window_ovf) begin
      r.fit_status = ST_OVERFLOW;
    end else if (pairs < 2) begin
      r.fit_status = ST_FEW;
    end else if (obs_peak == 0 || tpl_peak == 0) begin
      r.fit_status = ST_ZERO_PEAK;
    end else begin
      va = spread(wide_t'(pairs), wide_t'(obs_sq), wide_t'(obs_sum), wide_t'(obs_sum), pa);
      vb = spread(wide_t'(pairs), wide_t'(tpl_sq), wide_t'(tpl_sum), wide_t'(tpl_sum), pb);
      cv = spread(wide_t'(pairs), wide_t'(cross_sq), wide_t'(obs_sum), wide_t'(tpl_sum), pc);
      if (!pa || !pb) begin
        r.fit_status = ST_ZERO_VAR;
      end else begin
        s = longint'(obs_peak) + longint'(tpl_peak);
        if (pc) corr = quotient_search(va * vb, (wide_t'(1) << 30) * cv * cv, 1'b1);
        amp = quotient_search(wide_t'(s) * wide_t'(s),
                              (wide_t'(1) << 17) * wide_t'(obs_peak) * wide_t'(tpl_peak),
                              1'b0);
        r.fit_value = Q_W'(int_sqrt(longint'(corr) * longint'(amp)));
        r.correlation_value = Q_W'(corr);
        r.amplitude_fit = Q_W'(amp);
      end
    end
    r.peak_observed = obs_peak;
    r.peak_predicted = tpl_peak;
    r.window_length = LEN_W'(pairs);
    return r;
  endfunction

  // saturating accumulate that marks the window on overflow
  function automatic logic [SQ_W-1:0] sat_add(input logic [SQ_W-1:0] acc,
                                              input logic [SQ_W-1:0] add,
                                              input logic [SQ_W-1:0] top,
                                              inout logic ovf);
    if (add > top - acc) begin
      ovf = 1'b1;
      return top;
    end
    return acc + add;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SAMPLE_W-1:0] x, y;
    logic [63:0] scaled;
    fit_result_t got, want;
    if (!rst_ni) begin
      gain = SCALE_RESET;
      pairs = 0;
      obs_peak = '0;
      tpl_peak = '0;
      obs_sum = '0;
      tpl_sum = '0;
      obs_sq = '0;
      tpl_sq = '0;
      cross_sq = '0;
      window_ovf = 1'b0;
      expected_results.delete();
      fails = 0;
    end else begin
      // register write
      if (cfg_ch.valid && cfg_ch.ready) gain = cfg_ch.template_scale;

      // sample pair request
      if (in_ch.valid && in_ch.ready) begin
        x = in_ch.obs_sample;
        scaled = (64'(in_ch.template_sample) * 64'(gain) + 64'h80_0000) >> 24;
        y = (scaled > 64'(SAMPLE_TOP)) ? SAMPLE_TOP : scaled[SAMPLE_W-1:0];
        if (pairs >= WINDOW_MAX) begin
          window_ovf = 1'b1;
        end else begin
          pairs++;
          if (x > obs_peak) obs_peak = x;
          if (y > tpl_peak) tpl_peak = y;
          obs_sum = SUM_W'(sat_add(SQ_W'(obs_sum), SQ_W'(x), SQ_W'(SUM_TOP), window_ovf));
          tpl_sum = SUM_W'(sat_add(SQ_W'(tpl_sum), SQ_W'(y), SQ_W'(SUM_TOP), window_ovf));
          obs_sq = sat_add(obs_sq, SQ_W'(x) * SQ_W'(x), SQ_TOP, window_ovf);
          tpl_sq = sat_add(tpl_sq, SQ_W'(y) * SQ_W'(y), SQ_TOP, window_ovf);
          cross_sq = sat_add(cross_sq, SQ_W'(x) * SQ_W'(y), SQ_TOP, window_ovf);
        end
        if (in_ch.last_sample) begin
          expected_results.insert(expected_results.size(), window_result());
          pairs = 0;
          obs_peak = '0;
          tpl_peak = '0;
          obs_sum = '0;
          tpl_sum = '0;
          obs_sq = '0;
          tpl_sq = '0;
          cross_sq = '0;
          window_ovf = 1'b0;
        end
      end

      // result request
      if (out_ch.valid && out_ch.ready) begin
        got.fit_value = out_ch.fit_value;
        got.correlation_value = out_ch.correlation_value;
        got.amplitude_fit = out_ch.amplitude_fit;
        got.peak_observed = out_ch.peak_observed;
        got.peak_predicted = out_ch.peak_predicted;
        got.window_length = out_ch.window_length;
        got.fit_status = fit_status_e'(out_ch.fit_status);
        if (expected_results.size() == 0) begin
          $error("result with no window pending");
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (got.fit_value !== want.fit_value) begin
            $error("fit_value expected %0d actual %0d", want.fit_value, got.fit_value);
            fails++;
          end
          if (got.correlation_value !== want.correlation_value) begin
            $error("correlation_value expected %0d actual %0d",
                   want.correlation_value, got.correlation_value);
            fails++;
          end
          if (got.amplitude_fit !== want.amplitude_fit) begin
            $error("amplitude_fit expected %0d actual %0d", want.amplitude_fit,
                   got.amplitude_fit);
            fails++;
          end
          if (got.peak_observed !== want.peak_observed) begin
            $error("peak_observed expected %0h actual %0h", want.peak_observed,
                   got.peak_observed);
            fails++;
          end
          if (got.peak_predicted !== want.peak_predicted) begin
            $error("peak_predicted expected %0h actual %0h", want.peak_predicted,
                   got.peak_predicted);
            fails++;
          end
          if (got.window_length !== want.window_length) begin
            $error("window_length expected %0d actual %0d", want.window_length,
                   got.window_length);
            fails++;
          end
          if (got.fit_status !== want.fit_status) begin
            $error("fit_status expected %0d actual %0d", want.fit_status, got.fit_status);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending <= expected_results.size();
  end

endmodule
`default_nettype wire

[bench/tb_envelope_template_fit_top.sv]
// testbench top of the envelope template fit block: stimulus, idling and verdict
`default_nettype none
module tb_envelope_template_fit_top;
  import etf_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 900;
  localparam int unsigned HOLD_CYCLES = 2500;

  logic clk_i;
  logic rst_ni;
  int unsigned fail_count, pending;
  int unsigned snd_idle, rcv_idle;
  logic long_hold_go;
  int unsigned pair_total;

  etf_in_if  in_ch ();
  etf_out_if out_ch ();
  etf_cfg_if cfg_ch ();

  envelope_template_fit_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  etf_fit_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(8 * 12_000_000);
    $display("status: fail");
    $finish;
  end

  // result side: random stalls, one long hold while windows keep coming
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_go && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic send_pair(input logic [SAMPLE_W-1:0] o, input logic [SAMPLE_W-1:0] t,
                           input logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.obs_sample <= o;
    in_ch.template_sample <= t;
    in_ch.last_sample <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    pair_total++;
  endtask

  // one window of random content; len pairs, last one marked
  task automatic send_window(input int unsigned len);
    int unsigned shape, i;
    logic [SAMPLE_W-1:0] o, t, level;
    shape = $urandom_range(3);
    level = SAMPLE_W'($urandom);
    for (i = 0; i < len; i++) begin
      case (shape)
        0: begin
          o = SAMPLE_W'($urandom);
          t = SAMPLE_W'($urandom);
        end
        1: begin
          t = SAMPLE_W'($urandom_range(0, 1 << 20));
          o = t + SAMPLE_W'($urandom_range(0, 4095));
        end
        2: begin
          o = SAMPLE_W'($urandom_range(0, 15));
          t = SAMPLE_W'($urandom_range(0, 15));
        end
        default: begin
          o = level;
          t = SAMPLE_W'($urandom);
        end
      endcase
      send_pair(o, t, i == len - 1);
    end
  endtask

  task automatic random_windows(input int unsigned pair_goal);
    int unsigned start, pick, len;
    start = pair_total;
    while (pair_total - start < pair_goal) begin
      pick = $urandom_range(99);
      if (pick < 8) len = 1;
      else if (pick < 85) len = $urandom_range(2, 12);
      else len = $urandom_range(13, 80);
      send_window(len);
    end
  endtask

  // wait until every result is back and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.template_scale <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [SCALE_W-1:0] scales[7];
    int unsigned p, i;
    scales = '{32'h0, 32'hFFFF_FFFF, 32'h0080_0000, 32'h0, 32'h0000_0001, SCALE_RESET, 32'h0};
    scales[3] = $urandom;
    scales[6] = $urandom_range(32'h0200_0000, 32'h0000_4000);
    pair_total = 0;
    long_hold_go = 1'b0;
    snd_idle = 0;
    rcv_idle = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.obs_sample = '0;
    in_ch.template_sample = '0;
    in_ch.last_sample = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.template_scale = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed windows at unit gain
    send_pair(24'd1000, 24'd2000, 1'b1);           // single pair
    send_pair(24'd0, 24'd5, 1'b0);                 // observed peak zero
    send_pair(24'd0, 24'd7, 1'b1);
    send_pair(24'd9, 24'd9, 1'b0);                 // no variance
    send_pair(24'd9, 24'd9, 1'b1);
    send_pair(24'hFFFFFF, 24'hFFFFFF, 1'b0);       // field extremes
    send_pair(24'd0, 24'd0, 1'b0);
    send_pair(24'hFFFFFF, 24'd0, 1'b0);
    send_pair(24'd0, 24'hFFFFFF, 1'b1);
    send_pair(24'd1, 24'd5, 1'b0);                 // negative correlation
    send_pair(24'd5, 24'd1, 1'b1);
    send_pair(24'd100, 24'd200, 1'b0);             // exact proportion
    send_pair(24'd200, 24'd400, 1'b0);
    send_pair(24'd300, 24'd600, 1'b1);
    send_pair(24'd0, 24'd0, 1'b1);                 // lone zero pair
    send_window(3);

    // phases over gain settings and idling patterns
    for (p = 0; p < 7; p++) begin
      drain();
      write_scale(scales[p]);
      case (p % 3)
        0: begin
          snd_idle = 6;
          rcv_idle = 87;
        end
        1: begin
          snd_idle = 87;
          rcv_idle = 6;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      if (p == 2) long_hold_go <= 1'b1;
      if (p == 3) begin
        // full window: the extra pair is dropped and flags overflow
        for (i = 0; i <= 4096; i++)
          send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom), i == 4096);
      end
      random_windows(260);
    end

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
hdl/etf_pkg.sv
hdl/etf_if.sv
hdl/etf_datapath.sv
hdl/etf_ctrl.sv
hdl/envelope_template_fit_top.sv
bench/etf_fit_checker.sv
bench/tb_envelope_template_fit_top.sv
